FILE: rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and codes of the indexed list engine: command and status
// codes and the control flags broadcast down the chain of list cells.
// ----------------------------------------------------------------------------
package ile_pkg;

   // Field widths fixed by the interface
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned INDEX_W = 7;
   localparam int unsigned CMD_W   = 4;
   localparam int unsigned STAT_W  = 2;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND   = 4'd0,
      CMD_GET      = 4'd1,
      CMD_SET      = 4'd2,
      CMD_POP_LAST = 4'd3,
      CMD_POP_AT   = 4'd4,
      CMD_CONTAINS = 4'd5,
      CMD_INSERT   = 4'd6,
      CMD_REMOVE   = 4'd7,
      CMD_SIZE     = 4'd8
   } cmd_type;

   // Status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // Update flags broadcast to every cell, already qualified by the checks
   typedef struct packed {
      logic append;
      logic set;
      logic insert;
      logic pop_at;
      logic remove;
   } cell_ctrl_type;

   // Found index reported when a remove finds no match (-1)
   localparam logic [INDEX_W-1:0] NOT_FOUND = '1;

endpackage

FILE: rtl/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of signed 32-bit words held in a chain of cells.
// ----------------------------------------------------------------------------
// Result: a result is registered and shown in the cycle after its command beat is taken.
// Throughput: one command per cycle while results are taken; every cell shifts and compares in
// parallel, and the single output register holds one pending result.
// Reset: the entry count and the output valid clear; words are not cleared
// and slots at or above the count are never read.
// ----------------------------------------------------------------------------
module indexed_list_engine
   import ile_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [INDEX_W-1:0]         req_index,
   input  logic signed [WORD_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [WORD_W-1:0]   rsp_read_value,
   output logic signed [INDEX_W-1:0]  rsp_found_index,
   output logic                       rsp_found,
   output logic [INDEX_W-1:0]         rsp_list_length,
   output logic [STAT_W-1:0]          rsp_status
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam logic [PW-1:0] CAP_V = PW'(CAPACITY);

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rd_ff,     rd_in;
   logic [INDEX_W-1:0] fidx_ff,   fidx_in;
   logic               fnd_ff,    fnd_in;
   logic [INDEX_W-1:0] len_ff;
   status_type         st_ff,     st_in;

   logic               accept;
   cmd_type            cmd;
   logic [PW-1:0]      idx_ext;
   logic [PW-1:0]      cnt_ext;
   logic               full;
   logic               idx_lt;
   logic               idx_le;
   logic               any_hit;
   logic [PW-1:0]      match_pos;
   logic [WORD_W-1:0]  sel_word;
   logic               grow;
   logic               shrink;
   cell_ctrl_type      ctrl;

   logic [WORD_W-1:0]  words  [CAPACITY];
   logic [CAPACITY:0]  prefix;
   logic [CAPACITY-1:0] firsts;

   // Handshake: take a beat whenever the output register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign cmd     = cmd_type'(req_command);
   assign idx_ext = PW'(req_index);
   assign cnt_ext = PW'(count_ff);
   assign full    = cnt_ext == CAP_V;
   assign idx_lt  = idx_ext < cnt_ext;
   assign idx_le  = idx_ext <= cnt_ext;
   assign any_hit = prefix[CAPACITY];

   // Update flags for the cells
   always_comb begin
      ctrl        = '0;
      ctrl.append = accept && cmd == CMD_APPEND && !full;
      ctrl.set    = accept && cmd == CMD_SET && idx_lt;
      ctrl.insert = accept && cmd == CMD_INSERT && idx_le && !full;
      ctrl.pop_at = accept && cmd == CMD_POP_AT && idx_lt;
      ctrl.remove = accept && cmd == CMD_REMOVE;
   end

   // Chain of list cells
   assign prefix[0] = 1'b0;
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_W-1:0] left_w;
      logic [WORD_W-1:0] right_w;
      if (i == 0) begin : g_l0
         assign left_w = words[i];
      end else begin : g_ln
         assign left_w = words[i-1];
      end
      if (i == CAPACITY - 1) begin : g_rl
         assign right_w = words[i];
      end else begin : g_rn
         assign right_w = words[i+1];
      end
      ile_cell #(
         .POS (i),
         .PW  (PW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .idx        (idx_ext),
         .count      (cnt_ext),
         .value      (req_value),
         .left_word  (left_w),
         .right_word (right_w),
         .prefix_in  (prefix[i]),
         .prefix_out (prefix[i+1]),
         .first      (firsts[i]),
         .word       (words[i])
      );
   end

   // Encode position of the first match
   always_comb begin
      match_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (firsts[i]) begin
            match_pos = match_pos | PW'(i);
         end
      end
   end

   // Word at the requested index
   assign sel_word = words[idx_ext[AW-1:0]];

   // Result and count update
   always_comb begin
      rd_in   = '0;
      fidx_in = '0;
      fnd_in  = 1'b0;
      st_in   = ST_OK;
      grow    = 1'b0;
      shrink  = 1'b0;
      unique case (cmd)
         CMD_APPEND: begin
            if (full) st_in = ST_FULL;
            else      grow  = 1'b1;
         end
         CMD_GET: begin
            if (!idx_lt) st_in = ST_RANGE;
            else         rd_in = sel_word;
         end
         CMD_SET: begin
            if (!idx_lt) st_in = ST_RANGE;
         end
         CMD_POP_LAST: begin
            if (count_ff == '0) st_in  = ST_EMPTY;
            else                shrink = 1'b1;
         end
         CMD_POP_AT: begin
            if (!idx_lt) begin
               st_in = ST_RANGE;
            end else begin
               rd_in  = sel_word;
               shrink = 1'b1;
            end
         end
         CMD_CONTAINS: begin
            fnd_in = any_hit;
         end
         CMD_INSERT: begin
            if (!idx_le)   st_in = ST_RANGE;
            else if (full) st_in = ST_FULL;
            else           grow  = 1'b1;
         end
         CMD_REMOVE: begin
            if (any_hit) begin
               fidx_in = match_pos[INDEX_W-1:0];
               fnd_in  = 1'b1;
               shrink  = 1'b1;
            end else begin
               fidx_in = NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      count_in = count_ff;
      if (grow)   count_in = count_ff + 1'b1;
      if (shrink) count_in = count_ff - 1'b1;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff   <= rd_in;
         fidx_ff <= fidx_in;
         fnd_ff  <= fnd_in;
         len_ff  <= INDEX_W'(count_in);
         st_ff   <= st_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rd_ff;
   assign rsp_found_index = fidx_ff;
   assign rsp_found       = fnd_ff;
   assign rsp_list_length = len_ff;
   assign rsp_status      = st_ff;

endmodule

FILE: rtl/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell
// One list slot. Holds one word, compares it against the search word and
// passes the first-match flag on to the next cell. Loads, shifts up from
// its left neighbor or shifts down from its right neighbor as told.
// ----------------------------------------------------------------------------
module ile_cell
   import ile_pkg::*;
#(
   parameter int POS = 0,
   parameter int PW  = 7
) (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [PW-1:0]        idx,
   input  logic [PW-1:0]        count,
   input  logic [WORD_W-1:0]    value,
   input  logic [WORD_W-1:0]    left_word,
   input  logic [WORD_W-1:0]    right_word,
   input  logic                 prefix_in,
   output logic                 prefix_out,
   output logic                 first,
   output logic [WORD_W-1:0]    word
);

   localparam logic [PW-1:0] POS_V = PW'(POS);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;
   logic              live;
   logic              hit;

   // Match against the search word, only for slots in use
   assign live       = POS_V < count;
   assign hit        = live && (word_ff == value);
   assign prefix_out = prefix_in | hit;
   assign first      = hit & ~prefix_in;
   assign word       = word_ff;

   // Next word of the slot
   always_comb begin
      word_in = word_ff;
      if (ctrl.append && POS_V == count) begin
         word_in = value;
      end else if (ctrl.set && POS_V == idx) begin
         word_in = value;
      end else if (ctrl.insert) begin
         if (POS_V == idx) begin
            word_in = value;
         end else if (POS_V > idx) begin
            word_in = left_word;
         end
      end else if (ctrl.pop_at && POS_V >= idx) begin
         word_in = right_word;
      end else if (ctrl.remove && prefix_out) begin
         word_in = right_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

FILE: rtl/ile_checker.sv
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks of the indexed list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ile_checker
   import ile_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [CMD_W-1:0]           req_command,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [WORD_W-1:0]   rsp_read_value,
   input  logic signed [INDEX_W-1:0]  rsp_found_index,
   input  logic                       rsp_found,
   input  logic [INDEX_W-1:0]         rsp_list_length,
   input  logic [STAT_W-1:0]          rsp_status
);

   localparam logic [INDEX_W-1:0] CAP_LEN = INDEX_W'(CAPACITY);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_list_length) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   // Errors report no data
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0 && !rsp_found
         && rsp_found_index == '0)
      else $error("error result carries data");

   // Full is only reported at capacity, empty only at zero length
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_list_length == CAP_LEN)
      else $error("full reported below capacity");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_list_length == '0)
      else $error("empty reported on non-empty list");

   // A get command taken right after reset sees an empty list
   a_first_cmd: assert property (@(posedge clock)
      reset ##1 !reset && req_valid && req_ready && req_command == CMD_GET
         |=> rsp_valid && rsp_status == ST_RANGE && rsp_list_length == '0)
      else $error("list not empty after reset");

endmodule

bind indexed_list_engine ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (.*);

FILE: verif/list_checker.sv
// ----------------------------------------------------------------------------
// list_checker
// Watches the command and reply channels of the indexed list engine. Keeps
// a shadow copy of the list, works out the reply of every accepted command
// beat and compares each reply beat, field by field, in order.
// ----------------------------------------------------------------------------
module list_checker
   import ile_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [INDEX_W-1:0]         req_index,
   input  logic signed [WORD_W-1:0]   req_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [WORD_W-1:0]   rsp_read_value,
   input  logic signed [INDEX_W-1:0]  rsp_found_index,
   input  logic                       rsp_found,
   input  logic [INDEX_W-1:0]         rsp_list_length,
   input  logic [STAT_W-1:0]          rsp_status,
   output int                         fail_count,
   output int                         pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [WORD_W-1:0]  read_value;
      logic signed [INDEX_W-1:0] found_index;
      logic                      found;
      logic [INDEX_W-1:0]        list_length;
      status_type                status;
   } list_reply_type;

   // Shadow list and the replies still owed by the block
   logic signed [WORD_W-1:0] shadow_words [CAPACITY];
   int unsigned              shadow_count;
   list_reply_type           predicted_replies [$];

   // Drop the word at pos and close the gap
   function automatic void remove_word(int unsigned pos);
      for (int unsigned k = pos; k + 1 < shadow_count; k++) begin
         shadow_words[k] = shadow_words[k + 1];
      end
      shadow_count--;
   endfunction

   // Apply one command to the shadow list and return the reply it yields
   function automatic list_reply_type apply_list_command(logic [CMD_W-1:0] command,
                                                         logic [INDEX_W-1:0] index,
                                                         logic signed [WORD_W-1:0] value);
      list_reply_type r;
      int unsigned hit;
      r.read_value  = '0;
      r.found_index = '0;
      r.found       = 1'b0;
      r.status      = ST_OK;
      // first match, or shadow_count when there is none
      hit = shadow_count;
      for (int unsigned k = 0; k < shadow_count; k++) begin
         if (shadow_words[k] == value) begin
            hit = k;
            break;
         end
      end
      case (command)
         CMD_APPEND: begin
            if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               shadow_words[shadow_count] = value;
               shadow_count++;
            end
         end
         CMD_GET: begin
            if (index >= shadow_count) r.status = ST_RANGE;
            else r.read_value = shadow_words[index];
         end
         CMD_SET: begin
            if (index >= shadow_count) r.status = ST_RANGE;
            else shadow_words[index] = value;
         end
         CMD_POP_LAST: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else shadow_count--;
         end
         CMD_POP_AT: begin
            if (index >= shadow_count) begin
               r.status = ST_RANGE;
            end else begin
               r.read_value = shadow_words[index];
               remove_word(index);
            end
         end
         CMD_CONTAINS: begin
            r.found = (hit < shadow_count);
         end
         CMD_INSERT: begin
            if (index > shadow_count) begin
               r.status = ST_RANGE;
            end else if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (int unsigned k = shadow_count; k > index; k--) begin
                  shadow_words[k] = shadow_words[k - 1];
               end
               shadow_words[index] = value;
               shadow_count++;
            end
         end
         CMD_REMOVE: begin
            if (hit < shadow_count) begin
               remove_word(hit);
               r.found_index = hit[INDEX_W-1:0];
               r.found       = 1'b1;
            end else begin
               r.found_index = NOT_FOUND;
            end
         end
         default: ; // size and unused codes change nothing
      endcase
      r.list_length = shadow_count[INDEX_W-1:0];
      return r;
   endfunction

   function automatic void compare_field(string name, longint predicted, longint actual);
      if (predicted != actual) begin
         $error("%s mismatch: expected %0d, actual %0d", name, predicted, actual);
         fail_count++;
      end
   endfunction

   // Reply beat is checked before the command beat of the same edge is
   // predicted: a reply is registered, so the two never belong together.
   always @(posedge clock) begin
      list_reply_type oldest;
      if (reset) begin
         shadow_count = 0;
         predicted_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_replies.size() == 0) begin
               $error("reply beat with no command outstanding");
               fail_count++;
            end else begin
               oldest = predicted_replies.pop_front();
               compare_field("read_value", oldest.read_value, rsp_read_value);
               compare_field("found_index", oldest.found_index, rsp_found_index);
               compare_field("found", oldest.found, rsp_found);
               compare_field("list_length", oldest.list_length, rsp_list_length);
               compare_field("status", oldest.status, rsp_status);
            end
         end
         if (req_valid && req_ready) begin
            predicted_replies.push_back(apply_list_command(req_command, req_index,
                                                           req_value));
         end
      end
      pending_results = predicted_replies.size();
   end

endmodule

FILE: verif/indexed_list_engine_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_tb
// Drives command beats into the indexed list engine: a short directed run
// over empty-list errors, word extremes and every command, then random
// phases that fill the list to full and drain it back to empty, with
// random gaps on both channels and one long reply hold-off.
// ----------------------------------------------------------------------------
module indexed_list_engine_tb;
   import ile_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH    = 64;
   localparam int RANDOM_BEATS  = 1200;
   localparam int PHASE_BEATS   = 100;
   localparam int MAX_GAP       = 18;
   localparam int HOLD_AT_REPLY = 400;
   localparam int HOLD_CYCLES   = 150;

   // codes the block has no command for
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

   typedef enum int {PHASE_GROW, PHASE_SHRINK, PHASE_MIXED} phase_type;

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   logic [CMD_W-1:0]          req_command = '0;
   logic [INDEX_W-1:0]        req_index   = '0;
   logic signed [WORD_W-1:0]  req_value   = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   logic signed [WORD_W-1:0]  rsp_read_value;
   logic signed [INDEX_W-1:0] rsp_found_index;
   logic                      rsp_found;
   logic [INDEX_W-1:0]        rsp_list_length;
   logic [STAT_W-1:0]         rsp_status;

   int fail_count;
   int pending_results;
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;

   // small set of words so contains and remove often hit
   logic signed [WORD_W-1:0] word_pool [8];

   indexed_list_engine #(.CAPACITY(LIST_DEPTH)) u_top (.*);

   list_checker #(.CAPACITY(LIST_DEPTH)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

   // Offer one command beat after a random gap and hold it until taken
   task automatic send_command(logic [CMD_W-1:0] command, logic [INDEX_W-1:0] index,
                               logic signed [WORD_W-1:0] value);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= command;
      req_index   <= index;
      req_value   <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic signed [WORD_W-1:0] pick_word();
      if ($urandom_range(0, 9) < 7) return word_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Mostly small positions, some anywhere up to capacity, a few beyond
   function automatic logic [INDEX_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return INDEX_W'($urandom_range(0, 8));
      if (r < 9) return INDEX_W'($urandom_range(0, LIST_DEPTH));
      return INDEX_W'($urandom_range(0, 127));
   endfunction

   // Weights per command code, last slot covers the unused codes
   function automatic logic [CMD_W-1:0] pick_command(phase_type phase);
      int weights [10];
      int r;
      case (phase)
         PHASE_GROW:   weights = '{40, 10, 5, 5, 5, 5, 20, 5, 3, 2};
         PHASE_SHRINK: weights = '{10, 10, 5, 20, 20, 10, 5, 15, 3, 2};
         default:      weights = '{11, 11, 11, 11, 11, 11, 11, 11, 9, 3};
      endcase
      r = $urandom_range(0, 99);
      for (int c = 0; c < 9; c++) begin
         if (r < weights[c]) return c[CMD_W-1:0];
         r -= weights[c];
      end
      return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
   endfunction

   // Reply side: random stalls, one long hold-off to back the block up
   initial begin
      int stall;
      int replies_taken;
      bit held;
      replies_taken = 0;
      held          = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_idles ? $urandom_range(0, MAX_GAP) : 0;
         if (!held && replies_taken == HOLD_AT_REPLY) begin
            stall = HOLD_CYCLES;
            held  = 1'b1;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         replies_taken++;
         if (replies_taken % 64 == 0) receiver_idles = ($urandom_range(0, 3) != 0);
      end
   end

   // Stimulus and verdict
   initial begin
      phase_type phase_plan [6];
      logic [CMD_W-1:0] command;
      int useful_beats;
      phase_plan = '{PHASE_GROW, PHASE_GROW, PHASE_MIXED,
                     PHASE_SHRINK, PHASE_SHRINK, PHASE_MIXED};
      word_pool = '{32'sh0, -32'sh1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    32'sh1, $urandom, $urandom, $urandom};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty-list errors, word extremes, every command and unused codes
      send_command(CMD_SIZE,      0,   0);
      send_command(CMD_POP_LAST,  0,   0);
      send_command(CMD_GET,       0,   0);
      send_command(CMD_POP_AT,    0,   0);
      send_command(CMD_SET,       0,   7);
      send_command(CMD_INSERT,    1,   7);
      send_command(CMD_REMOVE,    0,   5);
      send_command(CMD_INSERT,    0,   32'sh7FFF_FFFF);
      send_command(CMD_APPEND,    0,   32'sh8000_0000);
      send_command(CMD_APPEND,    127, -32'sh1);
      send_command(CMD_INSERT,    3,   0);
      send_command(CMD_GET,       0,   0);
      send_command(CMD_GET,       3,   0);
      send_command(CMD_GET,       127, 0);
      send_command(CMD_SET,       1,   32'sh5555_5555);
      send_command(CMD_CONTAINS,  0,   32'sh7FFF_FFFF);
      send_command(CMD_CONTAINS,  0,   12345);
      send_command(CMD_REMOVE,    0,   -32'sh1);
      send_command(CMD_POP_AT,    0,   0);
      send_command(CMD_INSERT,    64,  3);
      send_command(CMD_UNUSED_LO, 5,   1);
      send_command(CMD_UNUSED_HI, 127, -32'sh1);
      send_command(CMD_POP_LAST,  0,   0);
      send_command(CMD_SIZE,      0,   0);

      // random phases; unused codes do not count toward the total
      useful_beats = 0;
      while (useful_beats < RANDOM_BEATS) begin
         if (useful_beats % PHASE_BEATS == 0) sender_idles = ($urandom_range(0, 3) != 0);
         command = pick_command(phase_plan[(useful_beats / PHASE_BEATS) % 6]);
         send_command(command, pick_position(), pick_word());
         if (command <= CMD_SIZE) useful_beats++;
      end
      req_valid <= 1'b0;

      // drain, then let the output register settle
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
